// ===== hdl/four_level_mmu_with_tlb_core_defines.svh =====
// Assertion macros for the four-level MMU core.
// Taken in by the checker file; depends on nothing else.
`ifndef FOUR_LEVEL_MMU_WITH_TLB_CORE_DEFINES_SVH
`define FOUR_LEVEL_MMU_WITH_TLB_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define FLMMU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define FLMMU_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/flmmu_pkg.sv =====
// Shared constants, codes and control structs of the four-level MMU core.
// Depends on nothing; taken in by every module of the block.
package flmmu_pkg;

  localparam int DEF_OFFSET_BITS = 12;
  localparam int DEF_INDEX_BITS  = 9;
  localparam int DEF_FRAMES      = 256;
  localparam int DEF_TLB_ENTRIES = 64;

  localparam int CMD_W    = 2;
  localparam int VA_W     = 48;
  localparam int STATUS_W = 2;
  localparam int PA_W     = 20;
  localparam int CNT_W    = 32;
  localparam int PSEL_W   = 3;

  localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MAP       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNMAP     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVED  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FRAMES = 2'd2;

  localparam logic [PSEL_W-1:0] PSEL_ZERO       = 3'd0;
  localparam logic [PSEL_W-1:0] PSEL_TLB        = 3'd1;
  localparam logic [PSEL_W-1:0] PSEL_ENTRY_OFF  = 3'd2;
  localparam logic [PSEL_W-1:0] PSEL_ENTRY_BASE = 3'd3;
  localparam logic [PSEL_W-1:0] PSEL_DATA_BASE  = 3'd4;

  typedef struct packed {
    logic                capture;
    logic                cnt_lookup;
    logic                cnt_miss;
    logic                tlb_inval;
    logic                tlb_fill_entry;
    logic                tlb_fill_data;
    logic                walk_init;
    logic                descend;
    logic                take_new;
    logic                scan_init;
    logic                scan_step;
    logic                fu_set;
    logic                fu_clr_data;
    logic                fu_free_entry;
    logic                data_take;
    logic                sweep_init;
    logic                init_wr;
    logic                zero_wr;
    logic                link_wr;
    logic                leaf_clr;
    logic                leaf_wr;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    logic                res_hit;
    logic [PSEL_W-1:0]   res_psel;
    logic                out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             ti_done;
    logic             tlb_match;
    logic             entry_ok;
    logic             lvl_zero;
    logic             lvl_one;
    logic             frame_free;
    logic             scan_last;
    logic             init_last;
    logic             zero_last;
    logic             out_busy;
  } dp_stat_t;

endpackage

// ===== hdl/flmmu_ctrl.sv =====
// Controller state machine of the four-level MMU core.
// Depends on flmmu_pkg; drives the datapath flmmu_dp by command struct.
module flmmu_ctrl import flmmu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  s,
  output ctrl_cmd_t c
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_TIDX     = 4'd2;
  localparam logic [3:0] S_TLB_CHK  = 4'd3;
  localparam logic [3:0] S_WALK_RD  = 4'd4;
  localparam logic [3:0] S_WALK_CHK = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CHK = 4'd7;
  localparam logic [3:0] S_ZERO     = 4'd8;
  localparam logic [3:0] S_LINK     = 4'd9;
  localparam logic [3:0] S_MAP_RD   = 4'd10;
  localparam logic [3:0] S_MAP_CHK  = 4'd11;
  localparam logic [3:0] S_LEAF     = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0] state, state_next;
  logic       alloc_tbl, alloc_tbl_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      alloc_tbl <= 1'b0;
    end else begin
      state     <= state_next;
      alloc_tbl <= alloc_tbl_next;
    end
  end

  always_comb begin
    c              = '0;
    state_next     = state;
    alloc_tbl_next = alloc_tbl;
    unique case (state)
      S_INIT: begin
        c.init_wr = 1'b1;
        if (s.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          c.capture  = 1'b1;
          state_next = S_TIDX;
        end
      end
      S_TIDX: begin
        if (s.ti_done) begin
          unique case (s.cmd)
            CMD_TRANSLATE: begin
              c.cnt_lookup = 1'b1;
              state_next   = S_TLB_CHK;
            end
            CMD_UNMAP: state_next = S_TLB_CHK;
            CMD_MAP: begin
              c.scan_init    = 1'b1;
              alloc_tbl_next = 1'b0;
              state_next     = S_SCAN_RD;
            end
            default: begin
              c.res_set    = 1'b1;
              c.res_status = ST_OK;
              c.res_psel   = PSEL_ZERO;
              state_next   = S_DONE;
            end
          endcase
        end
      end
      S_TLB_CHK: begin
        if (s.cmd == CMD_TRANSLATE && s.tlb_match) begin
          c.res_set    = 1'b1;
          c.res_status = ST_OK;
          c.res_hit    = 1'b1;
          c.res_psel   = PSEL_TLB;
          state_next   = S_DONE;
        end else begin
          c.cnt_miss  = (s.cmd == CMD_TRANSLATE);
          c.tlb_inval = (s.cmd == CMD_UNMAP) && s.tlb_match;
          c.walk_init = 1'b1;
          state_next  = S_WALK_RD;
        end
      end
      S_WALK_RD: state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        if (!s.entry_ok) begin
          c.res_set    = 1'b1;
          c.res_status = ST_UNMAPPED;
          c.res_psel   = PSEL_ZERO;
          state_next   = S_DONE;
        end else if (s.lvl_zero) begin
          c.res_set    = 1'b1;
          c.res_status = ST_OK;
          if (s.cmd == CMD_TRANSLATE) begin
            c.tlb_fill_entry = 1'b1;
            c.res_psel       = PSEL_ENTRY_OFF;
          end else begin
            c.fu_free_entry = 1'b1;
            c.leaf_clr      = 1'b1;
            c.res_psel      = PSEL_ENTRY_BASE;
          end
          state_next = S_DONE;
        end else begin
          c.descend  = 1'b1;
          state_next = S_WALK_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (s.frame_free) begin
          c.fu_set = 1'b1;
          if (alloc_tbl) begin
            c.sweep_init = 1'b1;
            state_next   = S_ZERO;
          end else begin
            c.data_take = 1'b1;
            c.walk_init = 1'b1;
            state_next  = S_MAP_RD;
          end
        end else if (s.scan_last) begin
          // out of frames: give back the data frame if a table was wanted
          c.fu_clr_data = alloc_tbl;
          c.res_set     = 1'b1;
          c.res_status  = ST_NO_FRAMES;
          c.res_psel    = PSEL_ZERO;
          state_next    = S_DONE;
        end else begin
          c.scan_step = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_ZERO: begin
        c.zero_wr = 1'b1;
        if (s.zero_last) state_next = S_LINK;
      end
      S_LINK: begin
        c.link_wr  = 1'b1;
        c.take_new = 1'b1;
        state_next = s.lvl_one ? S_LEAF : S_MAP_RD;
      end
      S_MAP_RD: state_next = S_MAP_CHK;
      S_MAP_CHK: begin
        if (s.entry_ok) begin
          c.descend  = 1'b1;
          state_next = s.lvl_one ? S_LEAF : S_MAP_RD;
        end else begin
          c.scan_init    = 1'b1;
          alloc_tbl_next = 1'b1;
          state_next     = S_SCAN_RD;
        end
      end
      S_LEAF: begin
        c.leaf_wr       = 1'b1;
        c.tlb_fill_data = 1'b1;
        c.res_set       = 1'b1;
        c.res_status    = ST_OK;
        c.res_psel      = PSEL_DATA_BASE;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!s.out_busy) begin
          c.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

// ===== hdl/flmmu_dp.sv =====
// Datapath of the four-level MMU core: table memory, frame bitmap, TLB,
// walk registers, counters and the output register. Depends on flmmu_pkg.
module flmmu_dp import flmmu_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int INDEX_BITS  = DEF_INDEX_BITS,
  parameter int FRAMES      = DEF_FRAMES,
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           c,
  output dp_stat_t            s,
  input  logic [CMD_W-1:0]    command,
  input  logic [VA_W-1:0]     virtual_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic                tlb_hit,
  output logic [PA_W-1:0]     physical_address,
  output logic [CNT_W-1:0]    lookup_count,
  output logic [CNT_W-1:0]    miss_count
);

  localparam int TBL      = 1 << INDEX_BITS;
  localparam int FB       = $clog2(FRAMES);
  localparam int TM_AW    = FB + INDEX_BITS;
  localparam int TM_DEPTH = FRAMES * TBL;
  localparam int EW       = FB + 1;
  localparam int VPN_W    = 4 * INDEX_BITS;
  localparam int VX_W     = OFFSET_BITS + VPN_W;
  localparam int TI_W     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int TLB_W    = 1 + VPN_W + FB;
  localparam int MAX_A    = (TBL > FRAMES) ? TBL : FRAMES;
  localparam int INIT_LEN = (MAX_A > TLB_ENTRIES) ? MAX_A : TLB_ENTRIES;
  localparam int SW_W     = $clog2(INIT_LEN);
  localparam bit TI_POW2  = ((TLB_ENTRIES & (TLB_ENTRIES - 1)) == 0);

  logic [CMD_W-1:0]    cmd_q;
  logic [VA_W-1:0]     va_q;
  logic [VX_W-1:0]     va_x;
  logic [VX_W-1:0]     in_x;
  logic [VPN_W-1:0]    vpn;
  logic [OFFSET_BITS-1:0] off;
  logic [INDEX_BITS-1:0]  idx;
  logic [TI_W-1:0]     ti;
  logic                ti_done;
  logic [FB-1:0]       tbl;
  logic [1:0]          lvl;
  logic [FB-1:0]       scan;
  logic [FB-1:0]       data;
  logic [SW_W-1:0]     sweep;
  logic [CNT_W-1:0]    lookups, misses;
  logic [STATUS_W-1:0] res_status;
  logic                res_hit;
  logic [PA_W-1:0]     res_pa;
  logic [FB+OFFSET_BITS-1:0] pa_full;

  logic [EW-1:0]    tm_mem [TM_DEPTH];
  logic             fu_mem [FRAMES];
  logic [TLB_W-1:0] tlb_mem [TLB_ENTRIES];
  logic [EW-1:0]    tm_q;
  logic             fu_q;
  logic [TLB_W-1:0] tlb_q;

  logic [TM_AW-1:0] tm_raddr, tm_waddr;
  logic             tm_we;
  logic [EW-1:0]    tm_wdata;
  logic [FB-1:0]    fu_waddr;
  logic             fu_we, fu_wdata;
  logic [TI_W-1:0]  tlb_waddr;
  logic             tlb_we;
  logic [TLB_W-1:0] tlb_wdata;

  logic [FB-1:0]    e_frame;
  logic             e_ok;
  logic [FB-1:0]    t_frame;
  logic [VPN_W-1:0] t_page;
  logic             t_valid;
  logic             sw_lt_tbl, sw_lt_frames, sw_lt_tlb;

  assign va_x    = VX_W'(va_q);
  assign in_x    = VX_W'(virtual_address);
  assign vpn     = va_x[OFFSET_BITS +: VPN_W];
  assign off     = va_x[OFFSET_BITS-1:0];
  assign e_frame = tm_q[FB:1];
  assign e_ok    = tm_q[0] && ({1'b0, e_frame} < (FB+1)'(FRAMES));
  assign t_valid = tlb_q[TLB_W-1];
  assign t_page  = tlb_q[FB +: VPN_W];
  assign t_frame = tlb_q[FB-1:0];

  assign sw_lt_tbl    = ({1'b0, sweep} < (SW_W+1)'(TBL));
  assign sw_lt_frames = ({1'b0, sweep} < (SW_W+1)'(FRAMES));
  assign sw_lt_tlb    = ({1'b0, sweep} < (SW_W+1)'(TLB_ENTRIES));

  always_comb begin
    case (lvl)
      2'd0:    idx = va_x[OFFSET_BITS +: INDEX_BITS];
      2'd1:    idx = va_x[OFFSET_BITS + INDEX_BITS +: INDEX_BITS];
      2'd2:    idx = va_x[OFFSET_BITS + 2*INDEX_BITS +: INDEX_BITS];
      default: idx = va_x[OFFSET_BITS + 3*INDEX_BITS +: INDEX_BITS];
    endcase
  end

  assign tm_raddr = {tbl, idx};

  // TLB slot: vpn modulo the entry count
  generate
    if (TLB_ENTRIES == 1) begin : g_ti_one
      assign ti      = '0;
      assign ti_done = 1'b1;
    end else if (TI_POW2) begin : g_ti_mask
      logic [TI_W-1:0] ti_r;
      always_ff @(posedge clk) begin
        if (c.capture) ti_r <= in_x[OFFSET_BITS +: TI_W];
      end
      assign ti      = ti_r;
      assign ti_done = 1'b1;
    end else begin : g_ti_serial
      // fold one index per step, top first: rem = (rem * 2^INDEX_BITS + index) mod N,
      // reduced by a reciprocal multiply and one correcting subtract
      localparam int XW = TI_W + INDEX_BITS;
      localparam logic [XW-1:0] RECIP = XW'((1 << XW) / TLB_ENTRIES);
      logic [TI_W-1:0]  rem;
      logic [VPN_W-1:0] vsh;
      logic [XW-1:0]    x_r;
      logic [XW-1:0]    q_r;
      logic [2*XW-1:0]  prod;
      logic [XW-1:0]    qn;
      logic [XW-1:0]    r_est;
      logic [TI_W-1:0]  r_fix;
      logic [2:0]       steps;
      logic [1:0]       ph;
      assign prod  = (2*XW)'(x_r) * (2*XW)'(RECIP);
      assign qn    = XW'(q_r * XW'(TLB_ENTRIES));
      assign r_est = x_r - qn;
      assign r_fix = (r_est >= XW'(TLB_ENTRIES)) ? TI_W'(r_est - XW'(TLB_ENTRIES)) :
                     TI_W'(r_est);
      always_ff @(posedge clk) begin
        if (rst) begin
          steps <= '0;
          ph    <= '0;
        end else if (c.capture) begin
          steps <= 3'd4;
          ph    <= '0;
        end else if (steps != '0) begin
          if (ph == 2'd2) begin
            ph    <= '0;
            steps <= steps - 3'd1;
          end else begin
            ph <= ph + 2'd1;
          end
        end
      end
      always_ff @(posedge clk) begin
        if (c.capture) begin
          rem <= '0;
          vsh <= in_x[OFFSET_BITS +: VPN_W];
        end else if (steps != '0) begin
          case (ph)
            2'd0: begin
              x_r <= {rem, vsh[VPN_W-1 -: INDEX_BITS]};
              vsh <= vsh << INDEX_BITS;
            end
            2'd1:    q_r <= prod[XW +: XW];
            default: rem <= r_fix;
          endcase
        end
      end
      assign ti      = rem;
      assign ti_done = (steps == '0);
    end
  endgenerate

  // write port selection
  always_comb begin
    tm_we    = 1'b0;
    tm_waddr = tm_raddr;
    tm_wdata = '0;
    if (c.init_wr) begin
      tm_we    = sw_lt_tbl;
      tm_waddr = TM_AW'(sweep[INDEX_BITS-1:0]);
    end
    if (c.zero_wr) begin
      tm_we    = 1'b1;
      tm_waddr = {scan, sweep[INDEX_BITS-1:0]};
    end
    if (c.link_wr) begin
      tm_we    = 1'b1;
      tm_wdata = {scan, 1'b1};
    end
    if (c.leaf_clr) tm_we = 1'b1;
    if (c.leaf_wr) begin
      tm_we    = 1'b1;
      tm_wdata = {data, 1'b1};
    end
  end

  always_comb begin
    fu_we    = 1'b0;
    fu_waddr = scan;
    fu_wdata = 1'b0;
    if (c.init_wr) begin
      fu_we    = sw_lt_frames;
      fu_waddr = sweep[FB-1:0];
      fu_wdata = (sweep == '0);
    end
    if (c.fu_set) begin
      fu_we    = 1'b1;
      fu_wdata = 1'b1;
    end
    if (c.fu_clr_data) begin
      fu_we    = 1'b1;
      fu_waddr = data;
    end
    if (c.fu_free_entry) begin
      fu_we    = 1'b1;
      fu_waddr = e_frame;
    end
  end

  always_comb begin
    tlb_we    = 1'b0;
    tlb_waddr = ti;
    tlb_wdata = '0;
    if (c.init_wr) begin
      tlb_we    = sw_lt_tlb;
      tlb_waddr = sweep[TI_W-1:0];
    end
    if (c.tlb_inval) tlb_we = 1'b1;
    if (c.tlb_fill_entry) begin
      tlb_we    = 1'b1;
      tlb_wdata = {1'b1, vpn, e_frame};
    end
    if (c.tlb_fill_data) begin
      tlb_we    = 1'b1;
      tlb_wdata = {1'b1, vpn, data};
    end
  end

  always_ff @(posedge clk) begin
    if (tm_we) tm_mem[tm_waddr] <= tm_wdata;
    tm_q <= tm_mem[tm_raddr];
  end

  always_ff @(posedge clk) begin
    if (fu_we) fu_mem[fu_waddr] <= fu_wdata;
    fu_q <= fu_mem[scan];
  end

  always_ff @(posedge clk) begin
    if (tlb_we) tlb_mem[tlb_waddr] <= tlb_wdata;
    tlb_q <= tlb_mem[ti];
  end

  always_comb begin
    case (c.res_psel)
      PSEL_TLB:        pa_full = {t_frame, off};
      PSEL_ENTRY_OFF:  pa_full = {e_frame, off};
      PSEL_ENTRY_BASE: pa_full = {e_frame, {OFFSET_BITS{1'b0}}};
      PSEL_DATA_BASE:  pa_full = {data, {OFFSET_BITS{1'b0}}};
      default:         pa_full = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (c.capture) begin
      cmd_q <= command;
      va_q  <= virtual_address;
    end
    if (c.walk_init) begin
      tbl <= '0;
      lvl <= 2'd3;
    end else if (c.descend) begin
      tbl <= e_frame;
      lvl <= lvl - 2'd1;
    end else if (c.take_new) begin
      tbl <= scan;
      lvl <= lvl - 2'd1;
    end
    if (c.scan_init)      scan <= '0;
    else if (c.scan_step) scan <= scan + 1'b1;
    if (c.data_take) data <= scan;
    if (c.res_set) begin
      res_status <= c.res_status;
      res_hit    <= c.res_hit;
      res_pa     <= PA_W'(pa_full);
    end
    if (c.out_load) begin
      status           <= res_status;
      tlb_hit          <= res_hit;
      physical_address <= res_pa;
      lookup_count     <= lookups;
      miss_count       <= misses;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      lookups   <= '0;
      misses    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (c.sweep_init)                   sweep <= '0;
      else if (c.init_wr || c.zero_wr)    sweep <= sweep + 1'b1;
      if (c.cnt_lookup && lookups != '1)  lookups <= lookups + 1'b1;
      if (c.cnt_miss && misses != '1)     misses <= misses + 1'b1;
      if (c.out_load)                     out_valid <= 1'b1;
      else if (!out_stall)                out_valid <= 1'b0;
    end
  end

  assign s.cmd        = cmd_q;
  assign s.ti_done    = ti_done;
  assign s.tlb_match  = t_valid && (t_page == vpn);
  assign s.entry_ok   = e_ok;
  assign s.lvl_zero   = (lvl == 2'd0);
  assign s.lvl_one    = (lvl == 2'd1);
  assign s.frame_free = !fu_q;
  assign s.scan_last  = (scan == FB'(FRAMES - 1));
  assign s.init_last  = (sweep == SW_W'(INIT_LEN - 1));
  assign s.zero_last  = (sweep == SW_W'(TBL - 1));
  assign s.out_busy   = out_valid && out_stall;

endmodule

// ===== hdl/four_level_mmu_with_tlb_core.sv =====
// Top level of the four-level MMU core with a direct-mapped TLB.
// Depends on flmmu_pkg, flmmu_ctrl and flmmu_dp.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | command, virtual_address
//   out     | out_valid/out_stall | status, tlb_hit, physical_address,
//           |                     | lookup_count, miss_count
//
// One item at a time. A TLB hit skips the table walk; a miss walks the table
// levels, reading and checking one entry per level; unmap always walks. Map
// scans the frame bitmap frame by frame and zeroes each table it creates.
// A TLB size that is not a power of two adds a serial modulo of the page
// number, folded one index level at a time.
// After reset an init sweep clears the root table, the TLB and the frame
// bitmap, marking frame 0 (the root table) used; in_stall stays high.
// A finished transaction waits in the output register while the next one is
// taken in; only its completion waits on out_stall.
module four_level_mmu_with_tlb_core import flmmu_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int INDEX_BITS  = DEF_INDEX_BITS,
  parameter int FRAMES      = DEF_FRAMES,
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    command,
  input  logic [VA_W-1:0]     virtual_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic                tlb_hit,
  output logic [PA_W-1:0]     physical_address,
  output logic [CNT_W-1:0]    lookup_count,
  output logic [CNT_W-1:0]    miss_count
);

  // command and status between the controller and the datapath
  ctrl_cmd_t c;
  dp_stat_t  s;

  flmmu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .s        (s),
    .c        (c)
  );

  flmmu_dp #(
    .OFFSET_BITS (OFFSET_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .FRAMES      (FRAMES),
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .c                (c),
    .s                (s),
    .command          (command),
    .virtual_address  (virtual_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .tlb_hit          (tlb_hit),
    .physical_address (physical_address),
    .lookup_count     (lookup_count),
    .miss_count       (miss_count)
  );

endmodule

// ===== hdl/flmmu_chk.sv =====
// Port-level checker of the four-level MMU core and its bind.
// Depends on flmmu_pkg and the assertion macros header.
`include "four_level_mmu_with_tlb_core_defines.svh"

module flmmu_chk import flmmu_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic                tlb_hit,
  input logic [PA_W-1:0]     physical_address,
  input logic [CNT_W-1:0]    lookup_count,
  input logic [CNT_W-1:0]    miss_count
);

  `FLMMU_CHECK_RST(a_reset_holds, rst |=> in_stall && !out_valid, "reset not held")
  `FLMMU_CHECK(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `FLMMU_CHECK(a_err_zero, out_valid && status != ST_OK |-> physical_address == 0 && !tlb_hit, "error with address")
  `FLMMU_CHECK(a_miss_le, out_valid |-> miss_count <= lookup_count, "misses above lookups")
  `FLMMU_CHECK(a_idle_take, in_valid && !in_stall |=> in_stall, "second transaction taken")

endmodule

bind four_level_mmu_with_tlb_core flmmu_chk u_chk (.*);
